// ----- hw/rtl/ttcw_pkg.sv -----
// Shared constants, types and command/status structs of the text terminal cell writer.
package ttcw_pkg;

   // Screen geometry
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 3;

   localparam int CELLS    = ROWS * COLUMNS;
   localparam int MAX_PUT  = (COLUMNS > TAB_WIDTH) ? COLUMNS : TAB_WIDTH;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int CURSOR_W = $clog2(CELLS + 1);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int COUNT_W  = $clog2(MAX_PUT + 1);

   // Field widths of the channels
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int CADDR_W = 11;
   localparam int PCNT_W  = 8;
   localparam int CPOS_W  = 11;
   localparam int STYLE_W = 8;
   localparam int CELL_W  = CHAR_W + STYLE_W;

   // Command codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOCK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   localparam logic [STYLE_W-1:0] RESET_STYLE = 8'd7;

   typedef enum logic [2:0] {
      KIND_PUT,
      KIND_BACK,
      KIND_LOCK,
      KIND_CLEAR,
      KIND_READ
   } kind_type;

   typedef enum logic [1:0] {
      OUT_PUT,
      OUT_BACK,
      OUT_PLAIN,
      OUT_READ
   } out_sel_type;

   typedef struct packed {
      logic        start;
      logic        put;
      logic        scroll_step;
      logic        fill_step;
      logic        fill_reset;
      logic        back;
      logic        sweep_clear;
      logic        load_out;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      kind_type req_kind;
      logic     at_end;
      logic     last_put;
      logic     scroll_last;
      logic     fill_last;
      logic     bs_blocked;
      logic     out_free;
   } stat_type;

endpackage

// ----- hw/rtl/ttcw_req_if.sv -----
// Command channel: valid/ready handshake with the command payload.
interface ttcw_req_if;
   import ttcw_pkg::*;

   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [CHAR_W-1:0]  char_code;
   logic [CADDR_W-1:0] cell_address;

   modport source (output valid, output func, output char_code, output cell_address,
                   input ready);
   modport sink   (input valid, input func, input char_code, input cell_address,
                   output ready);
endinterface

// ----- hw/rtl/ttcw_rsp_if.sv -----
// Result channel: valid/ready handshake with the result payload.
interface ttcw_rsp_if;
   import ttcw_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [PCNT_W-1:0] printed_count;
   logic [CPOS_W-1:0]        cursor_position;
   logic [CHAR_W-1:0]        read_char;
   logic [STYLE_W-1:0]       read_attr;

   modport source (output valid, output printed_count, output cursor_position,
                   output read_char, output read_attr, input ready);
   modport sink   (input valid, input printed_count, input cursor_position,
                   input read_char, input read_attr, output ready);
endinterface

// ----- hw/rtl/ttcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ttcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/ttcw_datapath.sv -----
// Datapath: cursor, column, lock, sweep counter, screen RAM and result register.
module ttcw_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ttcw_pkg::FUNC_W-1:0]       req_func,
   input  logic [ttcw_pkg::CHAR_W-1:0]       req_char_code,
   input  logic [ttcw_pkg::CADDR_W-1:0]      req_cell_address,
   input  logic                              csr_wr_en,
   input  logic [ttcw_pkg::STYLE_W-1:0]      csr_wr_data,
   input  ttcw_pkg::cmd_type                 cmd,
   output ttcw_pkg::stat_type                stat,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ttcw_pkg::PCNT_W-1:0] rsp_printed_count,
   output logic [ttcw_pkg::CPOS_W-1:0]       rsp_cursor_position,
   output logic [ttcw_pkg::CHAR_W-1:0]       rsp_read_char,
   output logic [ttcw_pkg::STYLE_W-1:0]      rsp_read_attr
);
   import ttcw_pkg::*;

   logic [STYLE_W-1:0]  style_ff, style_in;
   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [CURSOR_W-1:0] lock_ff, lock_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [CURSOR_W-1:0] sw_ff, sw_in;
   logic [COUNT_W-1:0]  remain_ff, remain_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CHAR_W-1:0]   put_char_ff, put_char_in;
   logic                rd_ok_ff, rd_ok_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [CPOS_W-1:0]   cpos_ff, cpos_in;
   logic [CHAR_W-1:0]   rchar_ff, rchar_in;
   logic [STYLE_W-1:0]  rattr_ff, rattr_in;

   kind_type            kind;
   logic                bs_blocked;
   logic                out_free;
   logic [COUNT_W:0]    put_total;
   logic [STYLE_W-1:0]  blank_attr;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [CELL_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [CELL_W-1:0]   ram_rd_data;

   logic [CURSOR_W-1:0] sw_prev;
   logic [CURSOR_W-1:0] sw_src;
   logic [CURSOR_W-1:0] cursor_prev;

   // Decode the pending command
   always_comb begin
      unique case (req_func)
         FUNC_WRITE: kind = (req_char_code == CH_BACKSPACE) ? KIND_BACK : KIND_PUT;
         FUNC_LOCK:  kind = KIND_LOCK;
         FUNC_CLEAR: kind = KIND_CLEAR;
         FUNC_READ:  kind = KIND_READ;
      endcase
   end

   assign bs_blocked  = (cursor_ff <= lock_ff) || (cursor_ff == '0);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign sw_prev     = sw_ff - CURSOR_W'(1);
   assign sw_src      = sw_ff + CURSOR_W'(COLUMNS);
   assign cursor_prev = cursor_ff - CURSOR_W'(1);
   assign blank_attr  = cmd.fill_reset ? RESET_STYLE : style_ff;
   assign put_total   = {1'b0, count_ff} + (COUNT_W + 1)'(1);

   assign stat.req_kind    = kind;
   assign stat.at_end      = cursor_ff == CURSOR_W'(CELLS);
   assign stat.last_put    = remain_ff == COUNT_W'(1);
   assign stat.scroll_last = sw_ff == CURSOR_W'(CELLS);
   assign stat.fill_last   = sw_ff == CURSOR_W'(CELLS - 1);
   assign stat.bs_blocked  = bs_blocked;
   assign stat.out_free    = out_free;

   // Architectural state
   always_comb begin
      style_in    = csr_wr_en ? csr_wr_data : style_ff;
      cursor_in   = cursor_ff;
      col_in      = col_ff;
      lock_in     = lock_ff;
      sw_in       = sw_ff;
      remain_in   = remain_ff;
      count_in    = count_ff;
      put_char_in = put_char_ff;
      rd_ok_in    = rd_ok_ff;

      if (cmd.start) begin
         unique case (kind)
            KIND_PUT: begin
               count_in = '0;
               if (req_char_code == CH_NEWLINE) begin
                  remain_in   = (col_ff == '0) ? COUNT_W'(COLUMNS)
                                               : COUNT_W'(COLUMNS) - COUNT_W'(col_ff);
                  put_char_in = CH_SPACE;
               end else if (req_char_code == CH_TAB) begin
                  remain_in   = COUNT_W'(TAB_WIDTH);
                  put_char_in = CH_SPACE;
               end else begin
                  remain_in   = COUNT_W'(1);
                  put_char_in = req_char_code;
               end
            end
            KIND_LOCK: lock_in = cursor_ff;
            KIND_CLEAR: begin
               cursor_in = '0;
               col_in    = '0;
               lock_in   = '0;
               sw_in     = '0;
            end
            KIND_READ: rd_ok_in = 32'(req_cell_address) < 32'(CELLS);
            KIND_BACK: ;
            default: ;
         endcase
      end

      if (cmd.put) begin
         cursor_in = cursor_ff + CURSOR_W'(1);
         col_in    = (col_ff == COL_W'(COLUMNS - 1)) ? '0 : col_ff + COL_W'(1);
         remain_in = remain_ff - COUNT_W'(1);
         count_in  = count_ff + COUNT_W'(1);
      end

      if (cmd.back && !bs_blocked) begin
         cursor_in = cursor_prev;
         col_in    = (col_ff == '0) ? COL_W'(COLUMNS - 1) : col_ff - COL_W'(1);
      end

      if (cmd.sweep_clear) begin
         sw_in = '0;
      end else if (cmd.scroll_step || cmd.fill_step) begin
         sw_in = sw_ff + CURSOR_W'(1);
      end

      // Scroll done: the cursor drops one row, column is unchanged
      if (cmd.scroll_step && stat.scroll_last) begin
         cursor_in = cursor_ff - CURSOR_W'(COLUMNS);
      end
   end

   // Screen RAM ports
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_ff[ADDR_W-1:0];
      ram_wr_data = {put_char_ff, style_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = ADDR_W'(req_cell_address);

      priority if (cmd.put) begin
         ram_wr_en = 1'b1;
      end else if (cmd.back && !bs_blocked) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cursor_prev[ADDR_W-1:0];
         ram_wr_data = {CH_SPACE, style_ff};
      end else if (cmd.scroll_step) begin
         ram_wr_en   = sw_ff != '0;
         ram_wr_addr = sw_prev[ADDR_W-1:0];
         ram_wr_data = (sw_ff <= CURSOR_W'(CELLS - COLUMNS)) ? ram_rd_data
                                                            : {CH_SPACE, style_ff};
         ram_rd_en   = sw_ff < CURSOR_W'(CELLS - COLUMNS);
         ram_rd_addr = sw_src[ADDR_W-1:0];
      end else if (cmd.fill_step) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = sw_ff[ADDR_W-1:0];
         ram_wr_data = {CH_SPACE, blank_attr};
      end else begin
         ram_rd_en = cmd.start && (kind == KIND_READ);
      end
   end

   ttcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Result register captures the post-command cursor
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pcnt_in      = pcnt_ff;
      cpos_in      = cpos_ff;
      rchar_in     = rchar_ff;
      rattr_in     = rattr_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         cpos_in      = CPOS_W'(cursor_in);
         pcnt_in      = '0;
         rchar_in     = '0;
         rattr_in     = '0;
         unique case (cmd.out_sel)
            OUT_PUT:   pcnt_in = (32'(put_total) > 32'd127) ? PCNT_W'(127)
                                                            : PCNT_W'(put_total);
            OUT_BACK:  pcnt_in = -PCNT_W'(1);
            OUT_PLAIN: ;
            OUT_READ: begin
               if (rd_ok_ff) begin
                  rchar_in = ram_rd_data[CELL_W-1:STYLE_W];
                  rattr_in = ram_rd_data[STYLE_W-1:0];
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff     <= RESET_STYLE;
         cursor_ff    <= '0;
         col_ff       <= '0;
         lock_ff      <= '0;
         sw_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         style_ff     <= style_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         lock_ff      <= lock_in;
         sw_ff        <= sw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      remain_ff   <= remain_in;
      count_ff    <= count_in;
      put_char_ff <= put_char_in;
      rd_ok_ff    <= rd_ok_in;
      pcnt_ff     <= pcnt_in;
      cpos_ff     <= cpos_in;
      rchar_ff    <= rchar_in;
      rattr_ff    <= rattr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_printed_count   = pcnt_ff;
   assign rsp_cursor_position = cpos_ff;
   assign rsp_read_char       = rchar_ff;
   assign rsp_read_attr       = rattr_ff;
endmodule

// ----- hw/rtl/ttcw_ctrl.sv -----
// Controller: sequences each command through the datapath.
module ttcw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ttcw_pkg::stat_type stat,
   output ttcw_pkg::cmd_type  cmd
);
   import ttcw_pkg::*;

   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_PUT    = 8'b0000_0100,
      ST_SCROLL = 8'b0000_1000,
      ST_BACK   = 8'b0001_0000,
      ST_CLEAR  = 8'b0010_0000,
      ST_REPORT = 8'b0100_0000,
      ST_READ   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = OUT_PLAIN;

      unique case (state_ff)
         ST_INIT: begin
            cmd.fill_step  = 1'b1;
            cmd.fill_reset = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               unique case (stat.req_kind)
                  KIND_PUT:   state_in = ST_PUT;
                  KIND_BACK:  state_in = ST_BACK;
                  KIND_LOCK:  state_in = ST_REPORT;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  KIND_READ:  state_in = ST_READ;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_PUT: begin
            if (stat.at_end) begin
               cmd.sweep_clear = 1'b1;
               state_in        = ST_SCROLL;
            end else if (!stat.last_put) begin
               cmd.put = 1'b1;
            end else if (stat.out_free) begin
               cmd.put      = 1'b1;
               cmd.load_out = 1'b1;
               cmd.out_sel  = OUT_PUT;
               state_in     = ST_IDLE;
            end
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (stat.scroll_last) begin
               state_in = ST_PUT;
            end
         end
         ST_BACK: begin
            if (stat.out_free) begin
               cmd.back     = 1'b1;
               cmd.load_out = 1'b1;
               cmd.out_sel  = stat.bs_blocked ? OUT_PLAIN : OUT_BACK;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_sel  = OUT_READ;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- hw/rtl/text_terminal_cell_writer_top.sv -----
// Top level of the text terminal cell writer: controller plus datapath.
//
// Usage:
//   req_bus carries one command per beat (func, char_code, cell_address);
//   rsp_bus returns exactly one result beat per command, in order.
//   csr_wr_en/csr_wr_data load the style byte for each written or blanked
//   cell after the reset sweep; write it only while no command is in flight.
// Sequence (from the accepting edge to result valid):
//   printable character: one cell; tab: TAB_WIDTH cells; newline: 1 to
//   COLUMNS cells; backspace, lock, read: result loads from their own state
//   clear: ROWS*COLUMNS cells blanked (one screen cell written per cycle)
//   each scroll first starts the sweep from the put state, then
//   the screen RAM moves one cell per cycle through its single write port.
// Reset: the screen RAM is swept to spaces with style 7, one cell per
//   cycle, with req_bus.ready held low; the style register may be
//   written during that sweep.
// Stall: the result sits in an output register; a new command is taken
//   while it waits, and the next result holds until rsp_bus.ready frees it.
module text_terminal_cell_writer_top (
   input  logic                         clock,
   input  logic                         reset,
   ttcw_req_if.sink                     req_bus,
   ttcw_rsp_if.source                   rsp_bus,
   input  logic                         csr_wr_en,
   input  logic [ttcw_pkg::STYLE_W-1:0] csr_wr_data
);
   import ttcw_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequence each command
   ttcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold screen, cursor and the result register
   ttcw_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_func            (req_bus.func),
      .req_char_code       (req_bus.char_code),
      .req_cell_address    (req_bus.cell_address),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_bus.valid),
      .rsp_ready           (rsp_bus.ready),
      .rsp_printed_count   (rsp_bus.printed_count),
      .rsp_cursor_position (rsp_bus.cursor_position),
      .rsp_read_char       (rsp_bus.read_char),
      .rsp_read_attr       (rsp_bus.read_attr)
   );
endmodule

// ----- bench/tb_text_terminal_cell_writer_top.sv -----
// Self-checking testbench for the text terminal cell writer: directed and random command beats.
module tb_text_terminal_cell_writer_top;
   import ttcw_pkg::*;

   // Generous timeout: every beat paying a scroll plus the longest stalls, several times over.
   localparam int CYCLE_LIMIT = 5_000_000;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES = 50;
   localparam int ADDR_MAX = (1 << CADDR_W) - 1;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [STYLE_W-1:0] csr_wr_data;

   ttcw_req_if req_bus ();
   ttcw_rsp_if rsp_bus ();

   text_terminal_cell_writer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // One expected result beat.
   typedef struct {
      logic signed [PCNT_W-1:0] count;
      logic [CPOS_W-1:0]        cursor;
      logic [CHAR_W-1:0]        rd_char;
      logic [STYLE_W-1:0]       rd_attr;
   } screen_result_type;

   // Shadow copy of the screen, cursor, lock and style.
   logic [CHAR_W-1:0]  screen_char [CELLS];
   logic [STYLE_W-1:0] screen_attr [CELLS];
   int                 cur_pos;
   int                 lock_pos;
   logic [STYLE_W-1:0] style_byte;

   screen_result_type pending_results [$];

   int fail_count;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;

   // Free-running clock, period 8.
   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Screen predictor
   // ---------------------------------------------------------------------

   // Blank every cell with the current style; home the cursor and the lock.
   function automatic void blank_screen();
      for (int i = 0; i < CELLS; i++) begin
         screen_char[i] = CH_SPACE;
         screen_attr[i] = style_byte;
      end
      cur_pos  = 0;
      lock_pos = 0;
   endfunction

   // Move every row up by one and blank the bottom row.
   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         screen_char[i] = screen_char[i + COLUMNS];
         screen_attr[i] = screen_attr[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         screen_char[i] = CH_SPACE;
         screen_attr[i] = style_byte;
      end
      cur_pos = (cur_pos >= COLUMNS) ? cur_pos - COLUMNS : 0;
   endfunction

   // Write one cell at the cursor; scroll first when the cursor sits past the last cell.
   function automatic void put_cell(input logic [CHAR_W-1:0] ch);
      if (cur_pos >= CELLS)
         scroll_screen();
      if (cur_pos < CELLS) begin
         screen_char[cur_pos] = ch;
         screen_attr[cur_pos] = style_byte;
      end
      cur_pos++;
   endfunction

   // Handle a write command; return the number of cells printed (-1 for a backspace that moves, 0 if blocked).
   function automatic int write_glyph(input logic [CHAR_W-1:0] ch);
      int n;
      n = 0;
      if (ch == CH_NEWLINE) begin
         // A newline at a line start still emits one full blank line.
         if (cur_pos % COLUMNS == 0) begin
            put_cell(CH_SPACE);
            n++;
         end
         while (cur_pos % COLUMNS != 0) begin
            put_cell(CH_SPACE);
            n++;
         end
      end else if (ch == CH_TAB) begin
         repeat (TAB_WIDTH) begin
            put_cell(CH_SPACE);
            n++;
         end
      end else if (ch == CH_BACKSPACE) begin
         if (cur_pos <= lock_pos || cur_pos == 0)
            return 0;
         cur_pos--;
         if (cur_pos < CELLS) begin
            screen_char[cur_pos] = CH_SPACE;
            screen_attr[cur_pos] = style_byte;
         end
         n = -1;
      end else begin
         put_cell(ch);
         n = 1;
      end
      return n;
   endfunction

   // Apply one accepted command beat and queue the result it must produce.
   function automatic void apply_command(input logic [FUNC_W-1:0]  func,
                                         input logic [CHAR_W-1:0]  ch,
                                         input logic [CADDR_W-1:0] addr);
      screen_result_type res;
      int n;
      n = 0;
      res.rd_char = '0;
      res.rd_attr = '0;
      case (func)
         FUNC_WRITE: n = write_glyph(ch);
         FUNC_LOCK:  lock_pos = cur_pos;
         FUNC_CLEAR: blank_screen();
         FUNC_READ: begin
            if (addr < CELLS) begin
               res.rd_char = screen_char[addr];
               res.rd_attr = screen_attr[addr];
            end
         end
      endcase
      if (n > 127)
         n = 127;
      res.count  = PCNT_W'(n);
      res.cursor = CPOS_W'(cur_pos);
      pending_results.push_back(res);
   endfunction

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   // Drive ready at the falling edge: a forced hold-off first, else random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare every accepted result beat against the oldest prediction.
   always @(posedge clock) begin : check_results
      screen_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no command outstanding: cursor_position %0d",
                   rsp_bus.cursor_position);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.printed_count !== want.count) begin
               $error("printed_count: expected %0d, actual %0d",
                      want.count, rsp_bus.printed_count);
               fail_count++;
            end
            if (rsp_bus.cursor_position !== want.cursor) begin
               $error("cursor_position: expected %0d, actual %0d",
                      want.cursor, rsp_bus.cursor_position);
               fail_count++;
            end
            if (rsp_bus.read_char !== want.rd_char) begin
               $error("read_char: expected 0x%02h, actual 0x%02h",
                      want.rd_char, rsp_bus.read_char);
               fail_count++;
            end
            if (rsp_bus.read_attr !== want.rd_attr) begin
               $error("read_attr: expected 0x%02h, actual 0x%02h",
                      want.rd_attr, rsp_bus.read_attr);
               fail_count++;
            end
         end
      end
   end

   // Abort on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Command side
   // ---------------------------------------------------------------------

   // Offer one command beat; hold it until accepted, then predict its result.
   // Valid stays high on return so back-to-back beats need no extra edge.
   task automatic send_cmd(input logic [FUNC_W-1:0]  func,
                           input logic [CHAR_W-1:0]  ch,
                           input logic [CADDR_W-1:0] addr);
      @(negedge clock);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= func;
      req_bus.char_code    <= ch;
      req_bus.cell_address <= addr;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      apply_command(func, ch, addr);
   endtask

   // Drop valid after the last beat of a burst.
   task automatic release_bus();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // Hold until every predicted result has come back.
   task automatic wait_drain();
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Load the style register; only called with nothing in flight.
   task automatic load_style(input logic [STYLE_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      style_byte = value;
   endtask

   // Draw one random command. Clears are rare so the screen fills up and
   // scrolling stays busy; newlines are weighted up for the same reason.
   task automatic send_random_cmd();
      int pick;
      int sub;
      logic [CHAR_W-1:0]  ch;
      logic [CADDR_W-1:0] addr;
      pick = $urandom_range(999);
      sub  = $urandom_range(99);
      ch   = CHAR_W'($urandom_range(255));
      addr = ($urandom_range(99) < 85) ? CADDR_W'($urandom_range(CELLS - 1))
                                       : CADDR_W'($urandom_range(ADDR_MAX));
      if (pick < 700) begin
         if (sub < 25)
            ch = CH_NEWLINE;
         else if (sub < 33)
            ch = CH_TAB;
         else if (sub < 48)
            ch = CH_BACKSPACE;
         send_cmd(FUNC_WRITE, ch, addr);
      end else if (pick < 780) begin
         send_cmd(FUNC_LOCK, ch, addr);
      end else if (pick < 784) begin
         send_cmd(FUNC_CLEAR, ch, addr);
      end else begin
         send_cmd(FUNC_READ, ch, addr);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every command and the field extremes, starting from the reset screen.
   task automatic test_basic_commands();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_cmd(FUNC_READ, 8'd0, 11'd0);                       // reset cell: space, style 7
      send_cmd(FUNC_READ, 8'd0, CADDR_W'(CELLS));             // first address past the screen
      send_cmd(FUNC_READ, 8'hFF, CADDR_W'(ADDR_MAX));         // all address bits set
      send_cmd(FUNC_WRITE, CH_BACKSPACE, 11'd0);              // blocked at zero
      send_cmd(FUNC_WRITE, 8'h00, 11'd0);
      send_cmd(FUNC_WRITE, 8'hFF, CADDR_W'(ADDR_MAX));
      send_cmd(FUNC_WRITE, 8'h41, 11'd0);
      send_cmd(FUNC_WRITE, CH_BACKSPACE, 11'd0);              // takes effect
      send_cmd(FUNC_LOCK, 8'h00, 11'd0);
      send_cmd(FUNC_WRITE, CH_BACKSPACE, 11'd0);              // blocked at the lock
      send_cmd(FUNC_WRITE, CH_TAB, 11'd0);
      send_cmd(FUNC_WRITE, CH_NEWLINE, 11'd0);                // pad to the next line
      send_cmd(FUNC_WRITE, CH_NEWLINE, 11'd0);                // full blank line
      send_cmd(FUNC_READ, 8'h00, 11'd1);
      send_cmd(FUNC_CLEAR, 8'h00, 11'd0);
      send_cmd(FUNC_READ, 8'h00, 11'd1);
      release_bus();
      wait_drain();
   endtask

   // Fill the screen with blank lines, then hit the scroll point with a
   // newline and with a printable character.
   task automatic test_scroll_at_screen_end();
      load_style(8'hA5);
      repeat (ROWS)
         send_cmd(FUNC_WRITE, CH_NEWLINE, 11'd0);
      send_cmd(FUNC_WRITE, CH_NEWLINE, 11'd0);                // scroll, then a full line
      send_cmd(FUNC_WRITE, 8'h5A, 11'd0);                     // scroll, then one cell
      send_cmd(FUNC_READ, 8'h00, CADDR_W'(CELLS - COLUMNS));
      send_cmd(FUNC_READ, 8'h00, CADDR_W'(CELLS - 1));
      release_bus();
      wait_drain();
   endtask

   // Hold off the result side for a long stretch while commands keep coming,
   // so the block fills and stalls its input; then pause until drained.
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      repeat (24) begin
         if ($urandom_range(3) == 0)
            send_cmd(FUNC_READ, 8'h00, CADDR_W'($urandom_range(CELLS - 1)));
         else
            send_cmd(FUNC_WRITE, CHAR_W'($urandom_range(33, 126)), 11'd0);
      end
      release_bus();
      wait_drain();
   endtask

   // One random phase with its own style and idling mix.
   task automatic test_random_traffic(input logic [STYLE_W-1:0] style,
                                      input int idle_pct,
                                      input int stall_pct,
                                      input int beats);
      load_style(style);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (beats)
         send_random_cmd();
      release_bus();
      wait_drain();
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_WRITE;
      req_bus.char_code    = '0;
      req_bus.cell_address = '0;
      rsp_bus.ready        = 1'b0;
      fail_count           = 0;
      cycle_count          = 0;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      hold_left            = 0;
      style_byte           = RESET_STYLE;
      blank_screen();

      // Hold reset, then release it at a falling edge; the block's clearing sweep keeps ready low afterward.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_scroll_at_screen_end();
      test_output_backpressure();
      test_random_traffic(8'h00, 0, 0, 120);
      test_random_traffic(8'hFF, 66, 0, 120);
      test_random_traffic(STYLE_W'($urandom_range(255)), 0, 66, 120);
      test_random_traffic(STYLE_W'($urandom_range(255)), 20, 20, 120);

      // Give a stray beat time to show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
